// ----- hdl/rpu_pkg.sv -----
// rpu_pkg: shared types, codes and gray level tables for the raw pixel unpacker
// used by every module of the block but the checker; depends on nothing
package rpu_pkg;

    // configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SWAP_BYTES   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SKIP_COUNT   = 3'd4;

    // pixel format codes
    localparam logic [2:0] FMT_GRAY1    = 3'd0;
    localparam logic [2:0] FMT_GRAY2    = 3'd1;
    localparam logic [2:0] FMT_GRAY4    = 3'd2;
    localparam logic [2:0] FMT_GRAY8    = 3'd3;
    localparam logic [2:0] FMT_RGBX5551 = 3'd4;
    localparam logic [2:0] FMT_XRGB1555 = 3'd5;
    localparam logic [2:0] FMT_RGB565   = 3'd6;

    // reset value of the image width and height registers
    localparam logic [12:0] IMAGE_SIDE_RESET = 13'd64;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // how the back end expands one queued job
    typedef enum logic [2:0] {
        JM_NONE,
        JM_GRAY1,
        JM_GRAY2,
        JM_GRAY4,
        JM_GRAY8,
        JM_RGB
    } job_mode_t;

    // one queued job: gray jobs carry the byte in color[7:0], rgb jobs r/g/b
    typedef struct packed {
        logic      restart;
        job_mode_t mode;
        logic [23:0] color;
    } job_t;

    // settings seen by the front end
    typedef struct packed {
        logic [2:0]  pixel_format;
        logic        swap_bytes;
        logic [15:0] skip_count;
    } front_cfg_t;

    // settings seen by the back end
    typedef struct packed {
        logic [12:0] image_width;
        logic [12:0] image_height;
    } back_cfg_t;

    // two bit gray level
    function automatic logic [7:0] gray2_level(input logic [1:0] code);
        logic [7:0] v;
        unique case (code)
            2'd0: v = 8'h00;
            2'd1: v = 8'h55;
            2'd2: v = 8'hAA;
            2'd3: v = 8'hFF;
        endcase
        return v;
    endfunction

    // three bit gray level, from the low bits of a nibble
    function automatic logic [7:0] gray3_level(input logic [2:0] code);
        logic [7:0] v;
        unique case (code)
            3'd0: v = 8'h00;
            3'd1: v = 8'h24;
            3'd2: v = 8'h49;
            3'd3: v = 8'h6D;
            3'd4: v = 8'h92;
            3'd5: v = 8'hB6;
            3'd6: v = 8'hDA;
            3'd7: v = 8'hFF;
        endcase
        return v;
    endfunction

    // index of the last pixel a job expands to
    function automatic logic [2:0] last_index(input job_mode_t mode);
        logic [2:0] v;
        unique case (mode)
            JM_GRAY1: v = 3'd7;
            JM_GRAY2: v = 3'd3;
            JM_GRAY4: v = 3'd1;
            default:  v = 3'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/rpu_ifs.sv -----
// rpu_ifs: valid/ready channel interfaces for the byte and pixel streams
// depends on nothing
interface rpu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface rpu_pixel_if;
    logic        valid;
    logic        ready;
    logic [11:0] column;
    logic [11:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        run_end;

    modport source (output valid, output column, output row, output red, output green,
                    output blue, output run_end, input ready);
    modport sink   (input valid, input column, input row, input red, input green,
                    input blue, input run_end, output ready);
endinterface

// ----- hdl/rpu_front.sv -----
// rpu_front: accepts raw bytes, handles header skip and byte pairing, and turns
// each pixel byte or byte pair, and each frame start, into a job; depends on rpu_pkg and rpu_ifs
module rpu_front
    import rpu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rpu_byte_if.sink   byte_stream,
    input  front_cfg_t cfg,
    input  logic       q_full,
    output logic       q_push,
    output job_t       q_job
);

    logic [15:0] skip_left_reg, skip_left_next;
    logic        have_half_reg, have_half_next;
    logic [7:0]  held_reg, held_next;

    logic        accept;
    logic [15:0] skip_src;
    logic        half_src;
    logic [7:0]  d;
    logic [15:0] p;
    logic [23:0] rgb;

    assign byte_stream.ready = !q_full;
    assign accept = byte_stream.valid && byte_stream.ready;
    assign d      = byte_stream.data_byte;

    // frame start restarts skip and pairing before the byte is handled
    assign skip_src = byte_stream.frame_start ? cfg.skip_count : skip_left_reg;
    assign half_src = byte_stream.frame_start ? 1'b0 : have_half_reg;

    // assemble and decode a 16 bit pixel, first byte low unless swapped
    always_comb
    begin
        p = cfg.swap_bytes ? {held_reg, d} : {d, held_reg};
        unique case (cfg.pixel_format)
            FMT_RGBX5551: rgb = {p[15:11], 3'b000, p[10:6], 3'b000, p[5:1], 3'b000};
            FMT_XRGB1555: rgb = {p[14:10], 3'b000, p[9:5], 3'b000, p[4:0], 3'b000};
            default:      rgb = {p[15:11], 3'b000, p[10:5], 2'b00, p[4:0], 3'b000};
        endcase
    end

    // classify the transaction
    always_comb
    begin
        skip_left_next = skip_left_reg;
        have_half_next = have_half_reg;
        held_next      = held_reg;
        q_job.restart  = byte_stream.frame_start;
        q_job.mode     = JM_NONE;
        q_job.color    = {16'h0000, d};
        if (accept)
        begin
            held_next      = byte_stream.frame_start ? 8'h00 : held_reg;
            have_half_next = half_src;
            if (skip_src != 16'h0000)
            begin
                skip_left_next = skip_src - 16'd1;
            end
            else
            begin
                skip_left_next = 16'h0000;
                if (cfg.pixel_format == FMT_RGBX5551 || cfg.pixel_format == FMT_XRGB1555 ||
                    cfg.pixel_format == FMT_RGB565)
                begin
                    if (!half_src)
                    begin
                        held_next      = d;
                        have_half_next = 1'b1;
                    end
                    else
                    begin
                        have_half_next = 1'b0;
                        q_job.mode     = JM_RGB;
                        q_job.color    = rgb;
                    end
                end
                else
                begin
                    have_half_next = 1'b0;
                    unique case (cfg.pixel_format)
                        FMT_GRAY1: q_job.mode = JM_GRAY1;
                        FMT_GRAY2: q_job.mode = JM_GRAY2;
                        FMT_GRAY4: q_job.mode = JM_GRAY4;
                        FMT_GRAY8: q_job.mode = JM_GRAY8;
                        default:   q_job.mode = JM_NONE;
                    endcase
                end
            end
        end
    end

    // a job goes to the queue if it yields pixels or restarts coordinates
    assign q_push = accept && (byte_stream.frame_start || q_job.mode != JM_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_left_reg <= 16'h0000;
            have_half_reg <= 1'b0;
            held_reg      <= 8'h00;
        end
        else
        begin
            skip_left_reg <= skip_left_next;
            have_half_reg <= have_half_next;
            held_reg      <= held_next;
        end
    end

endmodule

// ----- hdl/rpu_queue.sv -----
// rpu_queue: short job queue that decouples the front end from the back end
// depends on rpu_pkg
module rpu_queue
    import rpu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head,
    output logic head_valid
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- hdl/rpu_back.sv -----
// rpu_back: expands queued jobs into pixels, one per cycle unless the output
// stalls, tracking raster coordinates; depends on rpu_pkg and rpu_ifs
module rpu_back
    import rpu_pkg::*;
#(
    parameter int MAX_SIDE = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  back_cfg_t   cfg,
    input  logic        q_valid,
    input  job_t        q_head,
    output logic        q_pop,
    rpu_pixel_if.source pixel_stream
);

    localparam int CW = $clog2(MAX_SIDE) + 1;
    localparam int SW = (CW > 13) ? CW : 13;

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [2:0]    idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [11:0]   column_reg, row_out_reg;
    logic [7:0]    red_reg, green_reg, blue_reg;
    logic          run_end_reg;

    logic [SW-1:0] w_raw, h_raw;
    logic [CW-1:0] w, h;
    logic          step, is_none, drop, last, emit, finish;
    logic [CW-1:0] base_col, base_row, c1, r1, c2, r2;
    logic [7:0]    sh1, sh2, sh4, gray;
    logic [23:0]   pix;

    // clamp width and height to 1..MAX_SIDE
    always_comb
    begin
        w_raw = SW'(cfg.image_width);
        h_raw = SW'(cfg.image_height);
        if (w_raw == '0)
            w = CW'(1);
        else if (w_raw > SW'(MAX_SIDE))
            w = CW'(MAX_SIDE);
        else
            w = CW'(w_raw);
        if (h_raw == '0)
            h = CW'(1);
        else if (h_raw > SW'(MAX_SIDE))
            h = CW'(MAX_SIDE);
        else
            h = CW'(h_raw);
    end

    assign step    = q_valid && (!out_valid_reg || pixel_stream.ready);
    assign is_none = (q_head.mode == JM_NONE);

    // coordinates: restart on a restart job's first step, then wrap when needed
    always_comb
    begin
        base_col = (idx_reg == 3'd0 && q_head.restart) ? '0 : col_reg;
        base_row = (idx_reg == 3'd0 && q_head.restart) ? '0 : row_reg;
        c1 = base_col;
        r1 = base_row;
        if (base_col >= w)
        begin
            c1 = '0;
            r1 = (base_row < h) ? base_row + 1'b1 : base_row;
        end
        drop = (r1 >= h);
        c2 = c1 + 1'b1;
        r2 = r1;
        if (c2 >= w)
        begin
            c2 = '0;
            r2 = r1 + 1'b1;
        end
    end

    // pick this pixel's bits from the packed byte
    always_comb
    begin
        sh1 = q_head.color[7:0] << idx_reg;
        sh2 = q_head.color[7:0] << {idx_reg[1:0], 1'b0};
        sh4 = q_head.color[7:0] << {idx_reg[0], 2'b00};
        unique case (q_head.mode)
            JM_GRAY1: gray = sh1[7] ? 8'h00 : 8'hFF;
            JM_GRAY2: gray = gray2_level(sh2[7:6]);
            JM_GRAY4: gray = gray3_level(sh4[6:4]);
            default:  gray = q_head.color[7:0];
        endcase
        pix = (q_head.mode == JM_RGB) ? q_head.color : {gray, gray, gray};
    end

    // the run ends at the job's last pixel or when the next one falls below the image
    assign last   = (idx_reg == last_index(q_head.mode)) || (r2 >= h);
    assign emit   = step && !is_none && !drop;
    assign finish = is_none || drop || last;
    assign q_pop  = step && finish;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        idx_next = idx_reg;
        if (step)
        begin
            idx_next = finish ? 3'd0 : idx_reg + 3'd1;
            if (is_none)
            begin
                col_next = base_col;
                row_next = base_row;
            end
            else if (drop)
            begin
                col_next = c1;
                row_next = r1;
            end
            else
            begin
                col_next = c2;
                row_next = r2;
            end
        end
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (pixel_stream.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            column_reg  <= 12'(c1);
            row_out_reg <= 12'(r1);
            red_reg     <= pix[23:16];
            green_reg   <= pix[15:8];
            blue_reg    <= pix[7:0];
            run_end_reg <= last;
        end
    end

    assign pixel_stream.valid   = out_valid_reg;
    assign pixel_stream.column  = column_reg;
    assign pixel_stream.row     = row_out_reg;
    assign pixel_stream.red     = red_reg;
    assign pixel_stream.green   = green_reg;
    assign pixel_stream.blue    = blue_reg;
    assign pixel_stream.run_end = run_end_reg;

endmodule

// ----- hdl/raw_pixel_unpacker_core.sv -----
// raw_pixel_unpacker_core: top level with configuration registers, front end,
// job queue and back end; depends on rpu_pkg, rpu_ifs, rpu_front, rpu_queue, rpu_back
//
// Expands a packed raw byte stream into RGB888 pixels with column/row. Bytes
// enter on byte_stream; a byte flagged frame_start restarts the header skip,
// coordinates and byte pairing. The front end accepts one byte per cycle
// while its four-entry job queue has room; header bytes, bytes of the unused
// format code and the first byte of a 16 bit pair take no back-end time unless
// they carry frame_start. The back end emits one pixel per cycle unless its output
// stalls; a byte yields 8 pixels for gray1, 4 for gray2, 2 for gray4, 1 for gray8
// and 1 per 16 bit pair. A job that yields none still passes the back end: a
// frame_start byte with no pixels, or a byte whose pixels all fall in rows at or
// past image_height, which are dropped. A byte whose pixels reach the last kept
// row stops at the last pixel kept. The pixel output is a register, so bytes keep
// flowing into the queue while a result waits. The user must write configuration
// via cfg_write/cfg_index/cfg_data only while idle; the block does not enforce it.
module raw_pixel_unpacker_core
    import rpu_pkg::*;
#(
    parameter int MAX_SIDE = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    rpu_byte_if.sink               byte_stream,
    rpu_pixel_if.source            pixel_stream,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [2:0]  pixel_format_reg;
    logic        swap_bytes_reg;
    logic [12:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [15:0] skip_count_reg;

    front_cfg_t front_cfg;
    back_cfg_t  back_cfg;
    logic       q_push, q_full, q_pop, q_valid;
    job_t       q_job, q_head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= FMT_GRAY1;
            swap_bytes_reg   <= 1'b0;
            image_width_reg  <= IMAGE_SIDE_RESET;
            image_height_reg <= IMAGE_SIDE_RESET;
            skip_count_reg   <= 16'h0000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[2:0];
                REG_SWAP_BYTES:   swap_bytes_reg   <= cfg_data[0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[12:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[12:0];
                REG_SKIP_COUNT:   skip_count_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign front_cfg.pixel_format = pixel_format_reg;
    assign front_cfg.swap_bytes   = swap_bytes_reg;
    assign front_cfg.skip_count   = skip_count_reg;
    assign back_cfg.image_width   = image_width_reg;
    assign back_cfg.image_height  = image_height_reg;

    // byte classification
    rpu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .cfg         (front_cfg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (q_job)
    );

    // job queue
    rpu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_valid)
    );

    // pixel expansion
    rpu_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (back_cfg),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .pixel_stream (pixel_stream)
    );

endmodule

// ----- hdl/rpu_checker.sv -----
// rpu_checker: port-level assertions for raw_pixel_unpacker_core, bound to it
// depends on the top level's ports only
module rpu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] column,
    input logic [11:0] row,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue,
    input logic        run_end
);

    // a stalled pixel stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(column) && $stable(row) &&
        $stable(red) && $stable(green) && $stable(blue) && $stable(run_end))
    else $error("stalled pixel changed");

    // no pixel shown while in reset
    assert property (@(posedge clk) !rst_n |-> !out_valid)
    else $error("pixel valid during reset");

    // inside one run, consecutive pixels step along the raster
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !run_end) ##1 (out_valid && out_ready) |->
        (column == 12'($past(column) + 12'd1) && row == $past(row)) ||
        (column == 12'd0 && row == 12'($past(row) + 12'd1)))
    else $error("pixel coordinates broke inside a run");

    // a run is not left open while the next pixel is shown at the row just before
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !run_end) ##1 (out_valid && out_ready) |->
        row != 12'($past(row) - 12'd1))
    else $error("row went back inside a run");

endmodule

bind raw_pixel_unpacker_core rpu_checker u_rpu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (pixel_stream.valid),
    .out_ready (pixel_stream.ready),
    .column    (pixel_stream.column),
    .row       (pixel_stream.row),
    .red       (pixel_stream.red),
    .green     (pixel_stream.green),
    .blue      (pixel_stream.blue),
    .run_end   (pixel_stream.run_end)
);
